/* rtl/core/slrt_pkg.sv */
// Shared types for the step length ratio test core.
// Used by slrt_lane and step_length_ratio_test_core; no dependencies.
`default_nettype none
package slrt_pkg;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_CMP1 = 7'b0001000,
    S_MUL2 = 7'b0010000,
    S_CMP2 = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/step_length_ratio_test_core.sv */
// Step length ratio test core (fraction to boundary for interior point).
// Channels: in_* carries lam, dlam, slack, dslack (signed Q16.16) and last;
// out_* carries step_length, unsigned with FRAC_BITS fraction bits, 1.0 max.
// Both channels use valid/stall: a transaction completes on a clock edge
// with valid high and stall low.
// One item at a time: in_stall is high from acceptance until the item
// is finished. Two lanes divide the multiplier pair and the slack pair in
// parallel in their bit-serial dividers, then the merge stage tests each
// pair in turn with a multiply state and a compare state, and the finish
// state returns the block to idle, where it takes the next item.
// An item with last set produces one transaction on out_*, then the running
// step returns to 1.0. Other items produce nothing.
// The result sits in an output register; while out_stall is high it holds,
// and a following last item waits in the finish cycle until it drains.
// Synchronous reset (rst_n low) sets the step to 1.0 and empties the block.
// Depends on slrt_pkg, slrt_lane, slrt_merge.
`default_nettype none
module step_length_ratio_test_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_lam,
  input  logic signed [31:0]    in_dlam,
  input  logic signed [31:0]    in_slack,
  input  logic signed [31:0]    in_dslack,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FRAC_BITS:0]    out_step_length
);
  import slrt_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  state_t state_r, state_nxt;
  logic [FRAC_BITS:0] step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [FRAC_BITS:0] out_step_r, out_step_nxt;

  logic signed [31:0] lam_r, dlam_r, slack_r, dslack_r;
  logic               last_r;

  logic               accept;
  lane_stat_t         stat0, stat1;
  logic [FRAC_BITS:0] cand0, cand1;
  logic               sel_slack;
  logic               mul_en;
  logic [FRAC_BITS:0] merged;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (accept) begin
      lam_r    <= in_lam;
      dlam_r   <= in_dlam;
      slack_r  <= in_slack;
      dslack_r <= in_dslack;
      last_r   <= in_last;
    end
  end

  slrt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_lam (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_lam),
    .dir   (in_dlam),
    .stat  (stat0),
    .cand  (cand0)
  );

  slrt_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_slack (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .value (in_slack),
    .dir   (in_dslack),
    .stat  (stat1),
    .cand  (cand1)
  );

  assign sel_slack = (state_r == S_MUL2) || (state_r == S_CMP2);
  assign mul_en    = (state_r == S_MUL1) || (state_r == S_MUL2);

  slrt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
    .clk      (clk),
    .mul_en   (mul_en),
    .step     (step_r),
    .dir      (sel_slack ? dslack_r : dlam_r),
    .value    (sel_slack ? slack_r : lam_r),
    .cand     (sel_slack ? cand1 : cand0),
    .step_nxt (merged)
  );

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_step_nxt  = out_step_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat0.done && stat1.done) state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = S_CMP1;
      S_CMP1: begin
        step_nxt  = merged;
        state_nxt = S_MUL2;
      end
      S_MUL2: state_nxt = S_CMP2;
      S_CMP2: begin
        step_nxt  = merged;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_step_nxt  = step_r;
          step_nxt      = ONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_step_r <= out_step_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_step_length = out_step_r;

  // running step never leaves [0, 1.0]
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= ONE) else $error("running step above 1.0");

  a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_DIV) && stat0.busy && stat1.busy)
    else $error("lanes not started on accepted transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_step_r))
    else $error("stalled result changed");

  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    stat0.done == stat1.done) else $error("lanes out of step");

endmodule
`default_nettype wire

/* rtl/core/slrt_lane.sv */
// One ratio lane: radix-2 restoring divider giving the saturated candidate
// -value/dir clamped to [0, 1.0]. Depends on slrt_pkg.
`default_nettype none
module slrt_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [31:0]       value,
  input  logic signed [31:0]       dir,
  output slrt_pkg::lane_stat_t     stat,
  output logic [FRAC_BITS:0]       cand
);
  import slrt_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 2);
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic            busy_r, busy_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [32:0]     rem_r, rem_nxt;
  logic [FRAC_BITS:0] dvd_r, dvd_nxt;
  logic [FRAC_BITS:0] q_r, q_nxt;
  logic [31:0]     dsr_r, dsr_nxt;
  logic            pos_r, pos_nxt;
  logic            sat_r, sat_nxt;

  logic [31:0] abs_v, abs_d;
  logic [33:0] trial;
  logic        ge;
  logic        done;
  logic [FRAC_BITS:0] q_clip;

  assign abs_v = value[31] ? 32'(-value) : 32'(value);
  assign abs_d = dir[31] ? 32'(-dir) : 32'(dir);
  assign trial = {rem_r, dvd_r[FRAC_BITS]};
  assign ge    = trial >= {2'b00, dsr_r};
  assign done  = busy_r && (cnt_r == '0);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    pos_nxt  = pos_r;
    sat_nxt  = sat_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(FRAC_BITS + 1);
      // |value| < 2|dir| keeps the quotient under 2^(FRAC_BITS+1)
      rem_nxt  = {2'b00, abs_v[31:1]};
      dvd_nxt  = {abs_v[0], {FRAC_BITS{1'b0}}};
      q_nxt    = '0;
      dsr_nxt  = abs_d;
      pos_nxt  = (value != 32'sd0) && (dir != 32'sd0) && (value[31] != dir[31]);
      sat_nxt  = {1'b0, abs_v} >= {abs_d, 1'b0};
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      rem_nxt = ge ? 33'(trial - {2'b00, dsr_r}) : trial[32:0];
      dvd_nxt = {dvd_r[FRAC_BITS-1:0], 1'b0};
      q_nxt   = {q_r[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
    pos_r <= pos_nxt;
    sat_r <= sat_nxt;
  end

  assign q_clip = (q_r > ONE) ? ONE : q_r;
  assign cand   = !pos_r ? '0 : (sat_r ? ONE : q_clip);

  assign stat.busy = busy_r;
  assign stat.done = done;

endmodule
`default_nettype wire

/* rtl/core/slrt_merge.sv */
// Merge stage: registered step*dir product and exact compare against
// -value*2^FRAC_BITS; picks the lane candidate or keeps the step.
`default_nettype none
module slrt_merge #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  mul_en,
  input  logic [FRAC_BITS:0]    step,
  input  logic signed [31:0]    dir,
  input  logic signed [31:0]    value,
  input  logic [FRAC_BITS:0]    cand,
  output logic [FRAC_BITS:0]    step_nxt
);
  localparam int PW = FRAC_BITS + 34;

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] vext;
  logic signed [PW-1:0] nscaled;
  logic                 take;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= $signed({1'b0, step}) * dir;
    end
  end

  assign vext     = {{(PW-32){value[31]}}, value};
  assign nscaled  = (-vext) <<< FRAC_BITS;
  assign take     = (dir != 32'sd0) && (prod_r < nscaled);
  assign step_nxt = take ? cand : step;

endmodule
`default_nettype wire

/* test/step_length_ratio_test_core_tb.sv */
// Self-checking testbench for step_length_ratio_test_core: drives vectors of
// multiplier/slack pairs and checks every emitted step against a local predictor.
// Depends on slrt_pkg and the step_length_ratio_test_core RTL only.
`default_nettype none
module step_length_ratio_test_core_tb;

  localparam int FRAC = 16;
  localparam logic [16:0] STEP_ONE = 17'd1 << FRAC;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [31:0] in_lam, in_dlam, in_slack, in_dslack;
  logic in_last;
  logic out_valid;
  logic out_stall;
  logic [16:0] out_step_length;

  logic [16:0] model_step;
  logic [16:0] expected_steps[$];
  int errors;
  int quiet_cnt;
  bit quiet;
  int idle_cycles;

  step_length_ratio_test_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_lam(in_lam), .in_dlam(in_dlam), .in_slack(in_slack), .in_dslack(in_dslack),
    .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_step_length(out_step_length)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // One ratio test: shrink (or grow) the step when step*dir < -value.
  function automatic logic [16:0] ratio_update(input logic [16:0] cur,
                                               input logic signed [31:0] value,
                                               input logic signed [31:0] dir);
    longint neg_scaled;
    longint cand;
    if (dir == 0) return cur;
    neg_scaled = -longint'(value) * (longint'(1) << FRAC);
    if (longint'(cur) * longint'(dir) < neg_scaled) begin
      cand = neg_scaled / longint'(dir);
      if (cand < 0) cand = 0;
      if (cand > longint'(STEP_ONE)) cand = STEP_ONE;
      return cand[16:0];
    end
    return cur;
  endfunction

  task automatic send_item(input logic signed [31:0] lam, input logic signed [31:0] dlam,
                           input logic signed [31:0] slack, input logic signed [31:0] dslack,
                           input logic last);
    if (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_lam    <= lam;
    in_dlam   <= dlam;
    in_slack  <= slack;
    in_dslack <= dslack;
    in_last   <= last;
    do @(posedge clk); while (in_stall);
    model_step = ratio_update(model_step, lam, dlam);
    model_step = ratio_update(model_step, slack, dslack);
    if (last) begin
      expected_steps.push_back(model_step);
      model_step = STEP_ONE;
    end
  endtask

  // Result side: random stall, compare every transaction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0)
        report_mismatch($sformatf("unexpected step %0d", out_step_length));
      else if (out_step_length !== expected_steps[0]) begin
        report_mismatch($sformatf("step_length got %0d exp %0d",
                                  out_step_length, expected_steps[0]));
        void'(expected_steps.pop_front());
      end else
        void'(expected_steps.pop_front());
    end
    out_stall <= (!quiet && $urandom_range(99) < 22);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0004_0000));
      2: return -$signed($urandom_range(0, 32'h0001_0000));
      3: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      4: return 0;
      default: return $signed($urandom_range(0, 32'h0000_ffff));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_dir();
    case ($urandom_range(5))
      0: return $urandom;
      1: return -$signed($urandom_range(1, 32'h0010_0000));
      2: return $signed($urandom_range(1, 32'h0010_0000));
      3: return 0;
      4: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return -$signed($urandom_range(1, 32'h0000_4000));
    endcase
  endfunction

  task automatic test_directed();
    send_item(32'sh8000_0000, 32'sh0000_0001, 0, 0, 1'b1);
    send_item(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 1'b1);
    send_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 1'b1);
    send_item(32'sh0001_0000, 0, 32'sh8000_0000, 0, 1'b1);          // zero directions
    send_item(32'sh0001_0000, -32'sh0001_0000, 0, 0, 1'b1);         // exact tie
    send_item(32'sh0000_8000, -32'sh0001_0000, 32'sh0000_4000, -32'sh0001_0000, 1'b1);
    send_item(32'sh0000_4000, -32'sh0001_0000, 0, 0, 1'b0);
    send_item(-32'sh0000_2000, 32'sh0001_0000, 0, 0, 1'b1);         // step kept (no growth)
    send_item(-32'sh0000_1000, 32'sh0000_0001, 0, 0, 1'b1);         // grow past 1.0
    send_item(0, -32'sh0001_0000, 0, 0, 1'b1);                      // step to zero
    send_item(32'sh0000_0001, 32'sh8000_0000, 32'sh0000_0001, 32'sh7fff_ffff, 1'b0);
    send_item(32'sh0003_0000, -32'sh0002_0000, 32'sh0000_c000, -32'sh0001_0000, 1'b0);
    send_item(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1);
    send_item(-32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 32'sh0000_8000, 1'b1);
  endtask

  task automatic test_random(input int n_items);
    int left;
    int vec_len;
    left = n_items;
    while (left > 0) begin
      vec_len = $urandom_range(1, 8);
      for (int k = 0; k < vec_len && left > 0; k++) begin
        send_item(pick_value(), pick_dir(), pick_value(), pick_dir(),
                  (k == vec_len - 1) || left == 1);
        left--;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_lam = 0;
    in_dlam = 0;
    in_slack = 0;
    in_dslack = 0;
    in_last = 1'b0;
    out_stall = 1'b0;
    errors = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    model_step = STEP_ONE;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    quiet = 1'b1;   // long stretch with no idling on either side
    test_random(300);
    quiet = 1'b0;
    test_random(540);
    in_valid <= 1'b0;
    quiet_cnt = 0;
    while (expected_steps.size() != 0 && quiet_cnt < 20000) begin
      @(posedge clk);
      quiet_cnt++;
    end
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_steps.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
